FILE: rtl/utp_pkg.sv
`timescale 1ns / 1ps

package utp_pkg;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 32;
	localparam int BASE_W  = 6;
	localparam int DIGIT_W = 6;
	localparam int POS_W   = 13;
	localparam int MAC_W   = VALUE_W + BASE_W + 1;
	localparam int OUT_W   = 48;

	// Position counter saturation point
	localparam logic [POS_W-1:0] MAX_CHARS = POS_W'(4096);

	// Radix values
	localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
	localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
	localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
	localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
	localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

	// Letter digits start at ten
	localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

	// Parser phases, one-hot
	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_LEAD      = 6'b000010,
		PH_AFTERSIGN = 6'b000100,
		PH_LEADZERO  = 6'b001000,
		PH_XPEND     = 6'b010000,
		PH_DIGITS    = 6'b100000
	} phase_t;

	// Classification of one character
	typedef struct packed {
		logic               is_space;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               digit_ok;
		logic [DIGIT_W-1:0] digit;
	} char_class_t;

	// Saturating position increment
	function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] r;
		r = (pos >= MAX_CHARS) ? MAX_CHARS : pos + POS_W'(1);
		return r;
	endfunction

endpackage

FILE: rtl/unsigned_integer_text_parser_core.sv
`timescale 1ns / 1ps

// Streaming text-to-unsigned converter in the manner of strtoul. One character
// is taken per clock cycle while the result side is not stalled: each transfer
// is registered in the input stage, then classified and folded into the 32-bit
// accumulator (one multiply by the radix plus the digit) when that stage
// advances, and the result register is loaded from there. That accumulator
// update is the loop that sets the rate. A result that waits on m_tready
// holds the input stage, so s_tready then follows m_tready. tuser marks the
// first character of a string; leading whitespace and one sign are skipped, a
// radix of 0 detects 0x/0 prefixes, and the first character that is not
// accepted yields one result. Characters after that are dropped until the next
// start flag. The radix register is latched at each string start; write it
// only while idle.
module unsigned_integer_text_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Radix register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [utp_pkg::BASE_W-1:0]      cfg_data,
	// Character stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] char_code
	input  logic                            s_tuser,  // [0] starts_string
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [31:0] parsed_value, [32] overflowed, [33] saw_digits, [46:34] end_offset,
	// [47] zero
	output logic [utp_pkg::OUT_W-1:0]       m_tdata
);

	// Configuration and parse state
	logic [utp_pkg::BASE_W-1:0]  number_base_q;
	utp_pkg::phase_t             phase_q;
	logic                        neg_q;
	logic [utp_pkg::BASE_W-1:0]  base_q;
	logic [utp_pkg::VALUE_W-1:0] acc_q;
	logic                        ovf_q;
	logic                        dig_q;
	logic [utp_pkg::POS_W-1:0]   pos_q;
	logic [utp_pkg::POS_W-1:0]   lde_q;

	// Input stage
	logic                        valid_s1;
	logic [utp_pkg::CHAR_W-1:0]  char_s1;
	logic                        start_s1;

	// Result register
	logic                        out_valid_q;
	logic [utp_pkg::OUT_W-1:0]   out_data_q;

	// Effective (start-adjusted) and next state
	utp_pkg::phase_t             e_phase, n_phase, eff_phase;
	logic                        e_neg, n_neg;
	logic [utp_pkg::BASE_W-1:0]  e_base, n_base, use_base;
	logic [utp_pkg::VALUE_W-1:0] e_acc, n_acc, fin_value;
	logic                        e_ovf, n_ovf;
	logic                        e_dig, n_dig;
	logic [utp_pkg::POS_W-1:0]   e_pos, n_pos, pos_next;
	logic [utp_pkg::POS_W-1:0]   e_lde, n_lde;
	logic [utp_pkg::MAC_W-1:0]   mac;
	logic                        try_digit, take, emit;

	logic                        advance, proc_fire;
	utp_pkg::char_class_t        cls;

	utp_char_class u_class (
		.char_code (char_s1),
		.cls       (cls)
	);

	// Handshake: the input stage moves whenever the result register can take data
	assign advance   = !out_valid_q || m_tready;
	assign proc_fire = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Parse one character against the current state
	always_comb begin
		if (start_s1) begin
			e_phase = utp_pkg::PH_LEAD;
			e_neg   = 1'b0;
			e_base  = number_base_q;
			e_acc   = '0;
			e_ovf   = 1'b0;
			e_dig   = 1'b0;
			e_pos   = '0;
			e_lde   = '0;
		end else begin
			e_phase = phase_q;
			e_neg   = neg_q;
			e_base  = base_q;
			e_acc   = acc_q;
			e_ovf   = ovf_q;
			e_dig   = dig_q;
			e_pos   = pos_q;
			e_lde   = lde_q;
		end

		n_phase   = e_phase;
		n_neg     = e_neg;
		n_base    = e_base;
		n_acc     = e_acc;
		n_ovf     = e_ovf;
		n_dig     = e_dig;
		n_pos     = e_pos;
		n_lde     = e_lde;
		pos_next  = utp_pkg::sat_next(e_pos);
		use_base  = e_base;
		try_digit = 1'b0;
		eff_phase = (e_phase == utp_pkg::PH_LEAD) ? utp_pkg::PH_AFTERSIGN : e_phase;

		if (e_phase != utp_pkg::PH_IDLE) begin
			n_pos = pos_next;
			if (e_phase == utp_pkg::PH_LEAD && cls.is_space) begin
				n_phase = utp_pkg::PH_LEAD;
			end else if (e_phase == utp_pkg::PH_LEAD && (cls.is_plus || cls.is_minus)) begin
				n_neg   = cls.is_minus;
				n_phase = utp_pkg::PH_AFTERSIGN;
			end else begin
				unique case (eff_phase)
					utp_pkg::PH_AFTERSIGN: begin
						if (cls.is_zero &&
							(e_base == utp_pkg::BASE_AUTO || e_base == utp_pkg::BASE_HEX)) begin
							n_dig   = 1'b1;
							n_lde   = pos_next;
							n_phase = utp_pkg::PH_LEADZERO;
						end else begin
							use_base  = (e_base == utp_pkg::BASE_AUTO) ? utp_pkg::BASE_DEC : e_base;
							try_digit = 1'b1;
						end
					end
					utp_pkg::PH_LEADZERO: begin
						if (cls.is_x) begin
							n_base  = utp_pkg::BASE_HEX;
							n_phase = utp_pkg::PH_XPEND;
						end else begin
							use_base  = (e_base == utp_pkg::BASE_AUTO) ? utp_pkg::BASE_OCT : e_base;
							try_digit = 1'b1;
						end
					end
					default: begin
						// Pending hex prefix and plain digit runs both use the latched radix
						try_digit = 1'b1;
					end
				endcase
			end
		end

		// Accept a digit below the radix, otherwise end the string
		take = try_digit && cls.digit_ok &&
			use_base >= utp_pkg::BASE_MIN && use_base <= utp_pkg::BASE_MAX &&
			cls.digit < use_base;
		emit = try_digit && !take;
		mac  = utp_pkg::MAC_W'(e_acc) * utp_pkg::MAC_W'(use_base) + utp_pkg::MAC_W'(cls.digit);

		if (try_digit) begin
			n_base = use_base;
		end
		if (take) begin
			if (mac[utp_pkg::MAC_W-1:utp_pkg::VALUE_W] != '0) begin
				n_ovf = 1'b1;
			end else begin
				n_acc = mac[utp_pkg::VALUE_W-1:0];
			end
			n_dig   = 1'b1;
			n_lde   = pos_next;
			n_phase = utp_pkg::PH_DIGITS;
		end
		if (emit) begin
			n_phase = utp_pkg::PH_IDLE;
		end

		// Saturate on overflow, negate modulo 2^32 on minus
		if (e_ovf) begin
			fin_value = '1;
		end else if (e_neg) begin
			fin_value = ~e_acc + utp_pkg::VALUE_W'(1);
		end else begin
			fin_value = e_acc;
		end
	end

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= utp_pkg::BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			number_base_q <= cfg_data;
		end
	end

	// Capture each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// Advance the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= utp_pkg::PH_IDLE;
			neg_q   <= 1'b0;
			base_q  <= utp_pkg::BASE_RESET;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			dig_q   <= 1'b0;
			pos_q   <= '0;
			lde_q   <= '0;
		end else if (proc_fire) begin
			phase_q <= n_phase;
			neg_q   <= n_neg;
			base_q  <= n_base;
			acc_q   <= n_acc;
			ovf_q   <= n_ovf;
			dig_q   <= n_dig;
			pos_q   <= n_pos;
			lde_q   <= n_lde;
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire && emit) begin
			out_data_q <= {1'b0, (e_dig ? e_lde : utp_pkg::POS_W'(0)), e_dig, e_ovf, fin_value};
		end
	end

	// A result ends the string
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire && emit |=> phase_q == utp_pkg::PH_IDLE)
		else $error("parser not idle after result");

	// Nothing comes out of an idle parser without a start flag
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire && phase_q == utp_pkg::PH_IDLE && !start_s1 |-> !emit)
		else $error("result from idle parser");

	// Overflow always reports all ones
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[31:0] == '1)
		else $error("overflow result not saturated");

	// No digits means zero value and zero offset
	a_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[33] |-> m_tdata[31:0] == '0 && m_tdata[46:34] == '0 && !m_tdata[32])
		else $error("digit-free result not empty");

	// Position counters stay within bound
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= utp_pkg::MAX_CHARS && lde_q <= pos_q)
		else $error("position counter out of range");

endmodule

FILE: rtl/utp_char_class.sv
`timescale 1ns / 1ps

module utp_char_class (
	input  logic [utp_pkg::CHAR_W-1:0] char_code,
	output utp_pkg::char_class_t       cls
);

	logic [utp_pkg::CHAR_W-1:0] digit_full;

	// Map ASCII digits and letters to their digit value
	always_comb begin
		digit_full   = '0;
		cls.digit_ok = 1'b0;
		if (char_code >= utp_pkg::CH_ZERO && char_code <= utp_pkg::CH_NINE) begin
			digit_full   = char_code - utp_pkg::CH_ZERO;
			cls.digit_ok = 1'b1;
		end else if (char_code >= utp_pkg::CH_LO_A && char_code <= utp_pkg::CH_LO_Z) begin
			digit_full   = char_code - utp_pkg::CH_LO_A + utp_pkg::LETTER_OFS;
			cls.digit_ok = 1'b1;
		end else if (char_code >= utp_pkg::CH_UP_A && char_code <= utp_pkg::CH_UP_Z) begin
			digit_full   = char_code - utp_pkg::CH_UP_A + utp_pkg::LETTER_OFS;
			cls.digit_ok = 1'b1;
		end
		cls.digit = digit_full[utp_pkg::DIGIT_W-1:0];

		// Flag the punctuation and prefix characters
		cls.is_space = (char_code == utp_pkg::CH_SPACE) ||
			(char_code >= utp_pkg::CH_TAB && char_code <= utp_pkg::CH_CR);
		cls.is_plus  = (char_code == utp_pkg::CH_PLUS);
		cls.is_minus = (char_code == utp_pkg::CH_MINUS);
		cls.is_zero  = (char_code == utp_pkg::CH_ZERO);
		cls.is_x     = (char_code == utp_pkg::CH_LO_X) || (char_code == utp_pkg::CH_UP_X);
	end

endmodule

FILE: dv/tb_unsigned_integer_text_parser_core.sv
`timescale 1ns / 1ps

module tb_unsigned_integer_text_parser_core;
	import utp_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int TAIL_CYCLES   = 8;
	localparam int PHASE_CHARS   = 104;
	localparam int REPORT_LIMIT  = 10;

	// One result item as it travels on m_tdata, highest field first
	typedef struct packed {
		logic             pad;
		logic [POS_W-1:0] end_ofs;
		logic             saw;
		logic             ovf;
		logic [31:0]      value;
	} result_t;

	// Tracks the conversion of each string and holds the numbers it still awaits
	class number_parse_board;
		logic [BASE_W-1:0] base_reg;
		phase_t            phase;
		logic              neg;
		logic [BASE_W-1:0] base;
		logic [31:0]       acc;
		logic              ovf;
		logic              dig;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  dend;
		result_t           awaited_numbers[$];
		int                mismatches;
		int                checked;
		int                strings;

		function new();
			base_reg   = BASE_DEC;
			phase      = PH_IDLE;
			neg        = 1'b0;
			base       = BASE_DEC;
			acc        = '0;
			ovf        = 1'b0;
			dig        = 1'b0;
			pos        = '0;
			dend       = '0;
			mismatches = 0;
			checked    = 0;
			strings    = 0;
		endfunction

		function void set_base(logic [BASE_W-1:0] v);
			base_reg = v;
		endfunction

		function logic [POS_W-1:0] bump(logic [POS_W-1:0] p);
			return (p >= MAX_CHARS) ? MAX_CHARS : p + 1'b1;
		endfunction

		// Digit value of a character, 255 when it is no digit at all
		function logic [7:0] digit_value(logic [7:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
			if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'd10;
			if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 8'd10;
			return 8'hFF;
		endfunction

		// Fold one digit in, saturating once the next step would pass 32 bits
		function void take_digit(logic [7:0] d, logic [POS_W-1:0] p);
			logic [31:0] cutoff;
			logic [31:0] cutlim;
			cutoff = 32'hFFFF_FFFF / base;
			cutlim = 32'hFFFF_FFFF % base;
			if (acc > cutoff || (acc == cutoff && d > cutlim))
				ovf = 1'b1;
			else
				acc = acc * base + d;
			dig  = 1'b1;
			dend = bump(p);
		endfunction

		function void finish_string();
			result_t r;
			if (ovf) r.value = 32'hFFFF_FFFF;
			else if (neg) r.value = -acc;
			else r.value = acc;
			r.ovf     = ovf;
			r.saw     = dig;
			r.end_ofs = dig ? dend : '0;
			r.pad     = 1'b0;
			awaited_numbers.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void digit_or_end(logic [7:0] c, logic [POS_W-1:0] p);
			logic [7:0] d;
			d = digit_value(c);
			if (base >= BASE_MIN && base <= BASE_MAX && d < base) begin
				take_digit(d, p);
				phase = PH_DIGITS;
			end else begin
				finish_string();
			end
		endfunction

		// Advance the conversion by one accepted character
		function void accept_char(logic [7:0] c, logic start);
			logic [POS_W-1:0] p;
			if (start) begin
				phase = PH_LEAD;
				neg   = 1'b0;
				base  = base_reg;
				acc   = '0;
				ovf   = 1'b0;
				dig   = 1'b0;
				pos   = '0;
				dend  = '0;
				strings++;
			end
			if (phase == PH_IDLE) return;
			p   = pos;
			pos = bump(p);

			// Skip whitespace and take one sign
			if (phase == PH_LEAD) begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
				if (c == CH_PLUS || c == CH_MINUS) begin
					neg   = (c == CH_MINUS);
					phase = PH_AFTERSIGN;
					return;
				end
				phase = PH_AFTERSIGN;
			end

			case (phase)
				PH_AFTERSIGN: begin
					if (c == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
						dig   = 1'b1;
						dend  = bump(p);
						phase = PH_LEADZERO;
					end else begin
						if (base == BASE_AUTO) base = BASE_DEC;
						digit_or_end(c, p);
					end
				end
				PH_LEADZERO: begin
					if (c == CH_LO_X || c == CH_UP_X) begin
						base  = BASE_HEX;
						phase = PH_XPEND;
					end else begin
						if (base == BASE_AUTO) base = BASE_OCT;
						digit_or_end(c, p);
					end
				end
				PH_XPEND: begin
					if (digit_value(c) < 8'd16) begin
						take_digit(digit_value(c), p);
						phase = PH_DIGITS;
					end else begin
						finish_string();
					end
				end
				default: digit_or_end(c, p);
			endcase
		endfunction

		// Compare one delivered result with the oldest awaited number
		function void compare_result(result_t got);
			result_t want;
			bit      bad;
			checked++;
			if (awaited_numbers.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: value=%h ovf=%b digits=%b end=%0d",
						got.value, got.ovf, got.saw, got.end_ofs);
				return;
			end
			want = awaited_numbers.pop_front();
			bad  = (got.value != want.value) || (got.ovf != want.ovf) ||
				(got.saw != want.saw) || (got.end_ofs != want.end_ofs) ||
				(got.pad != want.pad);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("result %0d: expected value=%h ovf=%b digits=%b end=%0d pad=%b",
						checked, want.value, want.ovf, want.saw, want.end_ofs, want.pad);
					$display("result %0d:      got value=%h ovf=%b digits=%b end=%0d pad=%b",
						checked, got.value, got.ovf, got.saw, got.end_ofs, got.pad);
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [BASE_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	number_parse_board parse_board;
	logic [8:0]        char_q[$];
	bit                str_head;
	logic [BASE_W-1:0] cur_base;
	int                src_idle_pct;
	int                rx_stall_pct;
	int                radix_count;
	int                cycle_count;

	unsigned_integer_text_parser_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Throttle the result side
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Watch every transfer on the three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) parse_board.compare_result(result_t'(m_tdata));
			if (cfg_valid && cfg_ready) parse_board.set_base(cfg_data);
			if (s_tvalid && s_tready) parse_board.accept_char(s_tdata, s_tuser);
		end
	end

	// Hard stop if the run hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Queue one character; the first after str_head is set carries the start flag
	task automatic push_char(logic [7:0] c);
		char_q.push_back({str_head, c});
		str_head = 1'b0;
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) return CH_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
	endfunction

	// Number string with random whitespace, sign, prefix, digits and end
	task automatic gen_number(logic [BASE_W-1:0] b);
		int              eff;
		int              n;
		int              sel;
		longint unsigned v;
		int              ds[$];
		str_head = 1'b1;
		repeat ($urandom_range(0, 2))
			push_char($urandom_range(0, 5) == 5 ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
		sel = $urandom_range(0, 3);
		if (sel == 0) push_char(CH_PLUS);
		else if (sel == 1) push_char(CH_MINUS);
		eff = b;
		if (b == BASE_AUTO || b == BASE_HEX) begin
			sel = $urandom_range(0, 3);
			if (sel == 0) begin
				push_char(CH_ZERO);
				push_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
				eff = BASE_HEX;
			end else if (sel == 1) begin
				push_char(CH_ZERO);
				eff = (b == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			end else if (b == BASE_AUTO) begin
				eff = BASE_DEC;
			end
		end
		// Digit body: short, long enough to overflow, or around the 32-bit limit
		sel = $urandom_range(0, 9);
		if (sel == 0 && eff >= BASE_MIN && eff <= BASE_MAX) begin
			v = 64'hFFFF_FFFF - 20 + $urandom_range(0, 40);
			while (v != 0) begin
				ds.push_front(int'(v % eff));
				v = v / eff;
			end
		end else begin
			n = (sel < 3) ? $urandom_range(8, 40) : $urandom_range(0, 7);
			repeat (n)
				ds.push_back((eff >= BASE_MIN && eff <= BASE_MAX) ?
					$urandom_range(0, eff - 1) : $urandom_range(0, 35));
		end
		foreach (ds[i]) push_char(digit_char(ds[i]));
		// Terminate, or leave it open so the next start abandons it
		sel = $urandom_range(0, 9);
		if (sel < 4) push_char(8'h00);
		else if (sel == 4) push_char(CH_SPACE);
		else if (sel == 5) push_char(8'h2E);
		else if (sel == 6) push_char(8'h80 | 8'($urandom_range(0, 127)));
		else if (sel == 7) push_char(8'($urandom_range(0, 255)));
		// Trailing bytes after the end are dropped
		repeat ($urandom_range(0, 2)) push_char(8'($urandom_range(0, 255)));
	endtask

	// Random bytes with random start flags
	task automatic gen_noise();
		str_head = ($urandom_range(0, 1) == 1);
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 5) == 0) str_head = 1'b1;
			push_char(8'($urandom_range(0, 255)));
		end
	endtask

	// Present queued characters, idling at random while the sink may stall
	task automatic stream_chars();
		logic [8:0] item;
		bit         done;
		done = 1'b0;
		while (!done) begin
			@(posedge clk);
			if (!s_tvalid || s_tready) begin
				if (char_q.size() == 0) begin
					s_tvalid <= 1'b0;
					done = 1'b1;
				end else if ($urandom_range(0, 99) < src_idle_pct) begin
					s_tvalid <= 1'b0;
				end else begin
					item = char_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= item[8];
					s_tdata  <= item[7:0];
				end
			end
		end
	endtask

	// Wait for every awaited number, then let the pipeline settle
	task automatic drain();
		@(posedge clk);
		while (parse_board.awaited_numbers.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(logic [BASE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		cur_base = v;
		radix_count++;
	endtask

	initial begin
		logic [BASE_W-1:0] phase_bases[12];
		parse_board  = new();
		cur_base     = BASE_RESET;
		src_idle_pct = 0;
		rx_stall_pct = 0;
		radix_count  = 0;
		phase_bases  = '{BASE_AUTO, BASE_MIN, BASE_MAX, BASE_HEX, BASE_OCT, 6'd1, 6'd63,
			6'd37, BASE_AUTO, BASE_DEC, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset radix: ignored byte, whitespace and minus, abandon, bare end
		str_head = 1'b0;
		push_char(8'h37);
		str_head = 1'b1;
		push_char(CH_SPACE); push_char(CH_CR); push_char(CH_MINUS);
		push_char(8'h34); push_char(8'h32); push_char(8'h00);
		str_head = 1'b1;
		push_char(CH_PLUS); push_char(CH_NINE); push_char(CH_NINE);
		str_head = 1'b1;
		push_char(8'h37); push_char(8'h2E);
		str_head = 1'b1;
		push_char(8'hFF);
		stream_chars();
		drain();

		// Directed, automatic radix: bare prefix, hex, octal
		write_base(BASE_AUTO);
		str_head = 1'b1;
		push_char(CH_ZERO); push_char(CH_LO_X); push_char(CH_LO_Z);
		str_head = 1'b1;
		push_char(CH_ZERO); push_char(CH_UP_X); push_char(8'h46); push_char(8'h66);
		push_char(8'h00);
		str_head = 1'b1;
		push_char(CH_ZERO); push_char(8'h31); push_char(8'h37); push_char(CH_SPACE);
		stream_chars();
		drain();

		// Random phases over radix settings and idle patterns
		foreach (phase_bases[ph]) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin src_idle_pct = 79; rx_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rx_stall_pct = 79; end
				default: begin src_idle_pct = 32; rx_stall_pct = 32; end
			endcase
			write_base(phase_bases[ph]);
			while (char_q.size() < PHASE_CHARS) begin
				if ($urandom_range(0, 9) < 8) gen_number(cur_base);
				else gen_noise();
			end
			// Close the phase with an empty string so nothing stays open
			str_head = 1'b1;
			push_char(8'h00);
			stream_chars();
			drain();
		end

		if (parse_board.awaited_numbers.size() != 0)
			parse_board.mismatches += parse_board.awaited_numbers.size();
		$display("Ran %0d strings under %0d radix writes with four idle patterns",
			parse_board.strings, radix_count);
		$display("Compared %0d results, %0d mismatching", parse_board.checked,
			parse_board.mismatches);
		if (parse_board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
